[sv/emb_sgd_pkg.sv]
// package: shared codes and control/status types for the embedding sgd update block
`default_nettype none
package emb_sgd_pkg;

	typedef enum logic [1:0] {
		MODE_LOAD   = 2'd0,
		MODE_UPDATE = 2'd1,
		MODE_READ   = 2'd2
	} mode_t;

	typedef enum logic {
		TBL_USER = 1'b0,
		TBL_ITEM = 1'b1
	} table_t;

	typedef enum logic [0:0] {
		REG_STEP_SIZE      = 1'b0,
		REG_MOMENTUM_COEFF = 1'b1
	} cfg_reg_t;

	localparam logic [4:0] USER_SKIP_ELEM = 5'd0;
	localparam logic [4:0] ITEM_SKIP_ELEM = 5'd1;

	typedef struct packed {
		logic clear;
		logic capture;
		logic addr_load;
		logic mem_read;
		logic vel_mul;
		logic vel_sum;
		logic emb_mul;
		logic commit;
	} ctrl_cmd_t;

	typedef struct packed {
		logic clear_last;
		logic out_busy;
	} dp_sts_t;

endpackage
`default_nettype wire

[sv/emb_sgd_ctrl.sv]
// controller: state machine sequencing the clearing pass and each element update
`default_nettype none
module emb_sgd_ctrl (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_stall,
	input  wire emb_sgd_pkg::dp_sts_t   sts,
	output emb_sgd_pkg::ctrl_cmd_t      cmd
);
	import emb_sgd_pkg::*;

	typedef enum logic [7:0] {
		ST_CLEAR = 8'b0000_0001,
		ST_IDLE  = 8'b0000_0010,
		ST_ADDR  = 8'b0000_0100,
		ST_READ  = 8'b0000_1000,
		ST_VMUL  = 8'b0001_0000,
		ST_VSUM  = 8'b0010_0000,
		ST_EMUL  = 8'b0100_0000,
		ST_DONE  = 8'b1000_0000
	} state_t;

	state_t state_q;
	state_t state_d;

	assign in_stall = (state_q != ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_CLEAR: begin
				cmd.clear = 1'b1;
				if (sts.clear_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_ADDR;
				end
			end
			ST_ADDR: begin
				cmd.addr_load = 1'b1;
				state_d       = ST_READ;
			end
			ST_READ: begin
				cmd.mem_read = 1'b1;
				state_d      = ST_VMUL;
			end
			ST_VMUL: begin
				cmd.vel_mul = 1'b1;
				state_d     = ST_VSUM;
			end
			ST_VSUM: begin
				cmd.vel_sum = 1'b1;
				state_d     = ST_EMUL;
			end
			ST_EMUL: begin
				cmd.emb_mul = 1'b1;
				state_d     = ST_DONE;
			end
			ST_DONE: begin
				if (!sts.out_busy) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

`ifndef SYNTHESIS
	a_accept_starts_item: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q == ST_ADDR))
		else $error("accepted beat did not start the address step");

	a_clear_ends_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR && sts.clear_last) |=> (state_q == ST_IDLE))
		else $error("clearing pass did not end in idle");

	a_commit_then_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> (state_q == ST_IDLE && !$past(sts.out_busy)))
		else $error("result committed over a stalled beat");
`endif

endmodule
`default_nettype wire

[sv/emb_sgd_dp.sv]
// datapath: embedding and velocity memories, momentum and step arithmetic, output register
`default_nettype none
module emb_sgd_dp #(
	parameter int EMB_DIM   = 32,
	parameter int NUM_USERS = 1024,
	parameter int NUM_ITEMS = 4096
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire emb_sgd_pkg::ctrl_cmd_t cmd,
	output emb_sgd_pkg::dp_sts_t        sts,
	input  wire logic [15:0]            step_size,
	input  wire logic [15:0]            momentum_coeff,
	input  wire logic [1:0]             mode,
	input  wire logic                   table_select,
	input  wire logic [11:0]            vector_index,
	input  wire logic [4:0]             element_index,
	input  wire logic signed [31:0]     value,
	output logic                        out_valid,
	input  wire logic                   out_stall,
	output logic signed [31:0]          embedding_value,
	output logic signed [31:0]          velocity_value,
	output logic                        saturated
);
	import emb_sgd_pkg::*;

	localparam int U_DEPTH   = NUM_USERS * EMB_DIM;
	localparam int I_DEPTH   = NUM_ITEMS * EMB_DIM;
	localparam int MAX_DEPTH = (U_DEPTH > I_DEPTH) ? U_DEPTH : I_DEPTH;
	localparam int UAW       = $clog2(U_DEPTH);
	localparam int IAW       = $clog2(I_DEPTH);
	localparam int MAW       = $clog2(MAX_DEPTH);
	localparam int CW1       = MAW + 1;

	logic [31:0] user_emb [U_DEPTH];
	logic [31:0] item_emb [I_DEPTH];
	logic [31:0] user_vel [U_DEPTH];
	logic [31:0] item_vel [I_DEPTH];

	logic [1:0]  mode_q;
	logic        tsel_q;
	logic [11:0] vec_q;
	logic [4:0]  elem_q;
	logic [31:0] val_q;
	logic        hit_q;
	logic [MAW-1:0] addr_q;
	logic [31:0] ue_rd_q;
	logic [31:0] ie_rd_q;
	logic [31:0] uv_rd_q;
	logic [31:0] iv_rd_q;
	logic signed [48:0] vprod_q;
	logic signed [48:0] eprod_q;
	logic [31:0] vel_new_q;
	logic        vclip_q;
	logic [MAW-1:0] clr_cnt_q;
	logic        out_valid_q;
	logic [31:0] emb_out_q;
	logic [31:0] vel_out_q;
	logic        sat_out_q;

	logic        in_hit;
	logic [31:0] emb_rd;
	logic [31:0] vel_rd;
	logic [32:0] vsat;
	logic [32:0] esat;
	logic        skip;
	logic        is_update;
	logic        clr_user;
	logic        clr_item;
	logic        uv_we;
	logic        iv_we;
	logic        ue_we;
	logic        ie_we;
	logic [31:0] vel_wd;
	logic [31:0] emb_wd;
	logic [MAW-1:0] wr_addr;
	logic [31:0] emb_res;
	logic [31:0] vel_res;
	logic        sat_res;

	// round half up to q8.24, add, saturate; returns {clip, value}
	function automatic logic [32:0] acc_sat(logic [31:0] base, logic signed [48:0] prod);
		logic signed [48:0] rnd;
		logic [33:0] sum;
		logic [32:0] res;
		rnd = prod + 49'sd32768;
		sum = {{2{base[31]}}, base} + {rnd[48], rnd[48:16]};
		if (!sum[33] && sum[32:31] != 2'b00) begin
			res = {1'b1, 32'h7FFF_FFFF};
		end else if (sum[33] && sum[32:31] != 2'b11) begin
			res = {1'b1, 32'h8000_0000};
		end else begin
			res = {1'b0, sum[31:0]};
		end
		return res;
	endfunction

	assign in_hit = (table_select == TBL_ITEM)
		? (17'(vector_index) < 17'(NUM_ITEMS))
		: (17'(vector_index) < 17'(NUM_USERS));

	// item capture and address
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			mode_q <= mode;
			tsel_q <= table_select;
			vec_q  <= vector_index;
			elem_q <= element_index;
			val_q  <= value;
			hit_q  <= in_hit && (9'(element_index) < 9'(EMB_DIM));
		end
		if (cmd.addr_load) begin
			addr_q <= MAW'(vec_q) * MAW'(EMB_DIM) + MAW'(elem_q);
		end
	end

	// registered memory reads
	always_ff @(posedge clk) begin
		if (cmd.mem_read) begin
			ue_rd_q <= user_emb[addr_q[UAW-1:0]];
			ie_rd_q <= item_emb[addr_q[IAW-1:0]];
			uv_rd_q <= user_vel[addr_q[UAW-1:0]];
			iv_rd_q <= item_vel[addr_q[IAW-1:0]];
		end
	end

	assign emb_rd = (tsel_q == TBL_ITEM) ? ie_rd_q : ue_rd_q;
	assign vel_rd = (tsel_q == TBL_ITEM) ? iv_rd_q : uv_rd_q;

	assign vsat = acc_sat(val_q, vprod_q);

	// momentum and step arithmetic
	always_ff @(posedge clk) begin
		if (cmd.vel_mul) begin
			vprod_q <= $signed({1'b0, momentum_coeff}) * $signed(vel_rd);
		end
		if (cmd.vel_sum) begin
			vel_new_q <= vsat[31:0];
			vclip_q   <= vsat[32];
		end
		if (cmd.emb_mul) begin
			eprod_q <= $signed({1'b0, step_size}) * $signed(vel_new_q);
		end
	end

	assign esat      = acc_sat(emb_rd, eprod_q);
	assign skip      = (elem_q == ((tsel_q == TBL_ITEM) ? ITEM_SKIP_ELEM : USER_SKIP_ELEM));
	assign is_update = (mode_q == MODE_UPDATE);

	// result selection
	always_comb begin
		emb_res = '0;
		vel_res = '0;
		sat_res = 1'b0;
		if (hit_q) begin
			case (mode_q)
				MODE_LOAD: begin
					emb_res = val_q;
					vel_res = vel_rd;
				end
				MODE_UPDATE: begin
					emb_res = skip ? emb_rd : esat[31:0];
					vel_res = vel_new_q;
					sat_res = vclip_q || (!skip && esat[32]);
				end
				MODE_READ: begin
					emb_res = emb_rd;
					vel_res = vel_rd;
				end
				default: begin
					emb_res = '0;
				end
			endcase
		end
	end

	// memory write control
	assign clr_user = cmd.clear && (CW1'(clr_cnt_q) < CW1'(U_DEPTH));
	assign clr_item = cmd.clear && (CW1'(clr_cnt_q) < CW1'(I_DEPTH));
	assign wr_addr  = cmd.clear ? clr_cnt_q : addr_q;
	assign vel_wd   = cmd.clear ? 32'd0 : vel_new_q;
	assign emb_wd   = is_update ? esat[31:0] : val_q;

	always_comb begin
		uv_we = clr_user;
		iv_we = clr_item;
		ue_we = 1'b0;
		ie_we = 1'b0;
		if (cmd.commit && hit_q) begin
			case (mode_q)
				MODE_LOAD: begin
					ue_we = (tsel_q == TBL_USER);
					ie_we = (tsel_q == TBL_ITEM);
				end
				MODE_UPDATE: begin
					uv_we = (tsel_q == TBL_USER);
					iv_we = (tsel_q == TBL_ITEM);
					ue_we = (tsel_q == TBL_USER) && !skip;
					ie_we = (tsel_q == TBL_ITEM) && !skip;
				end
				default: begin
					ue_we = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (uv_we) begin
			user_vel[wr_addr[UAW-1:0]] <= vel_wd;
		end
	end

	always_ff @(posedge clk) begin
		if (iv_we) begin
			item_vel[wr_addr[IAW-1:0]] <= vel_wd;
		end
	end

	always_ff @(posedge clk) begin
		if (ue_we) begin
			user_emb[addr_q[UAW-1:0]] <= emb_wd;
		end
	end

	always_ff @(posedge clk) begin
		if (ie_we) begin
			item_emb[addr_q[IAW-1:0]] <= emb_wd;
		end
	end

	// clearing counter and output beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clear) begin
				clr_cnt_q <= clr_cnt_q + MAW'(1);
			end
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			emb_out_q <= emb_res;
			vel_out_q <= vel_res;
			sat_out_q <= sat_res;
		end
	end

	assign sts.clear_last = (clr_cnt_q == MAW'(MAX_DEPTH - 1));
	assign sts.out_busy   = out_valid_q && out_stall;

	assign out_valid       = out_valid_q;
	assign embedding_value = emb_out_q;
	assign velocity_value  = vel_out_q;
	assign saturated       = sat_out_q;

endmodule
`default_nettype wire

[sv/embedding_sgd_momentum_update.sv]
// sequence: an accepted input beat steps through the address, read, velocity multiply,
//   velocity sum, embedding multiply and done states; done commits the registered
//   output beat once the output is not stalled, and in_stall stays high until then
// reset: velocity memories are zeroed by a clearing pass over
//   max(NUM_USERS, NUM_ITEMS) * EMB_DIM addresses, during which no input beat is taken
// top level: configuration registers and controller/datapath instances
`default_nettype none
module embedding_sgd_momentum_update #(
	parameter int EMB_DIM   = 32,
	parameter int NUM_USERS = 1024,
	parameter int NUM_ITEMS = 4096
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [0:0]         cfg_index,
	input  wire logic [15:0]        cfg_data,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [1:0]         mode,
	input  wire logic               table_select,
	input  wire logic [11:0]        vector_index,
	input  wire logic [4:0]         element_index,
	input  wire logic signed [31:0] value,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic signed [31:0]      embedding_value,
	output logic signed [31:0]      velocity_value,
	output logic                    saturated
);
	import emb_sgd_pkg::*;

	logic [15:0] step_size_q;
	logic [15:0] momentum_coeff_q;
	ctrl_cmd_t   cmd;
	dp_sts_t     sts;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_size_q      <= 16'd655;
			momentum_coeff_q <= 16'd0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_STEP_SIZE:      step_size_q      <= cfg_data;
				REG_MOMENTUM_COEFF: momentum_coeff_q <= cfg_data;
				default: begin
					step_size_q <= step_size_q;
				end
			endcase
		end
	end

	emb_sgd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	emb_sgd_dp #(
		.EMB_DIM   (EMB_DIM),
		.NUM_USERS (NUM_USERS),
		.NUM_ITEMS (NUM_ITEMS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.step_size       (step_size_q),
		.momentum_coeff  (momentum_coeff_q),
		.mode            (mode),
		.table_select    (table_select),
		.vector_index    (vector_index),
		.element_index   (element_index),
		.value           (value),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.embedding_value (embedding_value),
		.velocity_value  (velocity_value),
		.saturated       (saturated)
	);

endmodule
`default_nettype wire
